// ----- rtl/nrmc_pkg.sv -----
// Types, constants and helpers shared by the RMC sentence parser.
package nrmc_pkg;

  localparam int FRAC_DIGITS_DEF = 4;

  localparam logic [4:0] POS_MAX = 5'd31;
  localparam logic [3:0] FLD_MAX = 4'd15;

  // Field numbers within a sentence
  localparam logic [3:0] FLD_HDR  = 4'd0;
  localparam logic [3:0] FLD_TIME = 4'd1;
  localparam logic [3:0] FLD_LAT  = 4'd3;
  localparam logic [3:0] FLD_NS   = 4'd4;
  localparam logic [3:0] FLD_LON  = 4'd5;
  localparam logic [3:0] FLD_EW   = 4'd6;
  localparam logic [3:0] FLD_DATE = 4'd9;

  // Bits of the seen-fields mask
  localparam logic [3:0] SEEN_TIME = 4'b0001;
  localparam logic [3:0] SEEN_LAT  = 4'b0010;
  localparam logic [3:0] SEEN_LON  = 4'b0100;
  localparam logic [3:0] SEEN_DATE = 4'b1000;
  localparam logic [3:0] SEEN_ALL  = 4'b1111;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam logic [4:0] HDR_LEN       = 5'd6;
  localparam logic [4:0] TIME_DIGITS   = 5'd6;
  localparam logic [4:0] TIME_MIN_LEN  = 5'd7;
  localparam logic [4:0] COORD_MIN_LEN = 5'd7;
  localparam logic [4:0] COORD_DIGITS  = 5'd5;
  localparam logic [4:0] DOT_POS_MIN   = 5'd3;
  localparam logic [4:0] DOT_POS_MAX   = 5'd5;
  localparam logic [4:0] DATE_LEN      = 5'd6;

  localparam logic [6:0] HOUR_MAX  = 7'd23;
  localparam logic [6:0] MINSEC_MAX = 7'd59;
  localparam logic [6:0] DAY_MAX   = 7'd31;
  localparam logic [6:0] MONTH_MAX = 7'd12;
  localparam logic [11:0] YEAR_BASE = 12'd2000;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_sentence;
  } in_t;

  typedef struct packed {
    logic        valid_res;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [11:0] year_full;
    logic [29:0] latitude_units;
    logic [7:0]  latitude_hemisphere;
    logic [29:0] longitude_units;
    logic [7:0]  longitude_hemisphere;
  } out_t;

  // Expected talker/sentence id, one byte per position
  function automatic logic [7:0] hdr_char(input logic [2:0] p);
    logic [7:0] ch;
    case (p)
      3'd0:    ch = 8'h24; // '$'
      3'd1:    ch = 8'h47; // 'G'
      3'd2:    ch = 8'h50; // 'P'
      3'd3:    ch = 8'h52; // 'R'
      3'd4:    ch = 8'h4D; // 'M'
      3'd5:    ch = 8'h43; // 'C'
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/nmea_rmc_sentence_parser_top.sv -----
// RMC sentence parser: byte-wise field splitter, decoder and result register.
// The result is registered: out_valid rises in the cycle after the last byte is taken.
// Throughput: one byte per cycle; in_stall rises only while a result waits under
// out_stall, so the output register is the only point of back pressure.
// Reset (rst_n low, synchronous): clears the parser to the start of a sentence
// and drops any result that was still waiting.
module nmea_rmc_sentence_parser_top
  import nrmc_pkg::*;
#(
  parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // Fraction digits kept; later ones are checked and dropped
  localparam int KEEP = (FRAC_DIGITS < 4) ? FRAC_DIGITS : 4;

  // Parser state
  logic [3:0]  fld_r, fld_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic        err_r, err_nxt;
  logic [3:0]  seen_r, seen_nxt;
  logic [6:0]  hour_r, hour_nxt, min_r, min_nxt, sec_r, sec_nxt;
  logic [6:0]  day_r, day_nxt, mon_r, mon_nxt, yr_r, yr_nxt;
  logic [9:0]  deg_r, deg_nxt;
  logic [3:0]  cmt_r, cmt_nxt, cmo_r, cmo_nxt;
  logic [3:0]  frac_r [4];
  logic [3:0]  frac_nxt [4];
  logic        dot_seen_r, dot_seen_nxt, dot_ok_r, dot_ok_nxt;
  logic [2:0]  fcnt_r, fcnt_nxt;
  logic [29:0] lat_r, lat_nxt, lon_r, lon_nxt;
  logic [7:0]  latl_r, latl_nxt, lonl_r, lonl_nxt;

  // Result register
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  // Byte-stage values
  logic [7:0]  ch;
  logic [3:0]  dig;
  logic        last, is_comma, is_dig, accept;
  logic        b_err;
  logic [4:0]  b_pos;
  logic [6:0]  b_hour, b_min, b_sec, b_day, b_mon, b_yr;
  logic [9:0]  b_deg;
  logic [3:0]  b_cmt, b_cmo;
  logic [3:0]  b_frac [4];
  logic        b_dot_seen, b_dot_ok;
  logic [2:0]  b_fcnt;
  logic [7:0]  b_latl, b_lonl;

  // Close-stage values
  logic        c_err;
  logic [3:0]  c_seen;
  logic [29:0] c_lat, c_lon;
  logic [6:0]  cmin_val;
  logic [13:0] frac_val;
  logic [29:0] units;
  logic [3:0]  fld_adv;
  logic        e_err;
  logic [3:0]  e_seen;

  assign ch       = in_data.char_in;
  assign last     = in_data.end_of_sentence;
  assign dig      = 4'(ch - CH_0);
  assign is_comma = (ch == CH_COMMA);
  assign is_dig   = (ch >= CH_0) && (ch <= CH_9);
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Per-byte decode of the current field
  always_comb begin
    b_err      = err_r;
    b_hour     = hour_r;
    b_min      = min_r;
    b_sec      = sec_r;
    b_day      = day_r;
    b_mon      = mon_r;
    b_yr       = yr_r;
    b_deg      = deg_r;
    b_cmt      = cmt_r;
    b_cmo      = cmo_r;
    b_frac     = frac_r;
    b_dot_seen = dot_seen_r;
    b_dot_ok   = dot_ok_r;
    b_fcnt     = fcnt_r;
    b_latl     = latl_r;
    b_lonl     = lonl_r;
    if (is_comma) begin
      b_pos = pos_r;
    end else begin
      b_pos = (pos_r < POS_MAX) ? pos_r + 5'd1 : pos_r;
      case (fld_r)
        FLD_HDR: begin
          if (pos_r < HDR_LEN && ch != hdr_char(pos_r[2:0])) b_err = 1'b1;
        end
        FLD_TIME: begin
          if (pos_r < TIME_DIGITS) begin
            if (!is_dig) begin
              b_err = 1'b1;
            end else if (pos_r < 5'd2) begin
              b_hour = 7'(hour_r * 7'd10) + 7'(dig);
            end else if (pos_r < 5'd4) begin
              b_min = 7'(min_r * 7'd10) + 7'(dig);
            end else begin
              b_sec = 7'(sec_r * 7'd10) + 7'(dig);
            end
          end else if (pos_r == TIME_DIGITS && ch != CH_DOT) begin
            b_err = 1'b1;
          end
        end
        FLD_LAT, FLD_LON: begin
          if (!dot_seen_r) begin
            if (ch == CH_DOT) begin
              b_dot_seen = 1'b1;
              b_dot_ok   = (pos_r >= DOT_POS_MIN) && (pos_r <= DOT_POS_MAX);
            end else if (!is_dig) begin
              b_err = 1'b1;
            end else if (pos_r < COORD_DIGITS) begin
              // shift the digit through ones -> tens -> degrees
              b_deg = 10'(deg_r * 10'd10) + 10'(cmt_r);
              b_cmt = cmo_r;
              b_cmo = dig;
            end
          end else begin
            if (!is_dig) begin
              b_err = 1'b1;
            end else if (fcnt_r < 3'(KEEP)) begin
              b_frac[fcnt_r[1:0]] = dig;
              b_fcnt = fcnt_r + 3'd1;
            end
          end
        end
        FLD_NS: begin
          if (pos_r == 5'd0) b_latl = ch;
        end
        FLD_EW: begin
          if (pos_r == 5'd0) b_lonl = ch;
        end
        FLD_DATE: begin
          if (pos_r < DATE_LEN) begin
            if (!is_dig) begin
              b_err = 1'b1;
            end else if (pos_r < 5'd2) begin
              b_day = 7'(day_r * 7'd10) + 7'(dig);
            end else if (pos_r < 5'd4) begin
              b_mon = 7'(mon_r * 7'd10) + 7'(dig);
            end else begin
              b_yr = 7'(yr_r * 7'd10) + 7'(dig);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Field close: length and range checks, coordinate assembly
  always_comb begin
    cmin_val = 7'(b_cmt * 7'd10) + 7'(b_cmo);
    frac_val = 14'(b_frac[0] * 14'd1000) + 14'(b_frac[1] * 14'd100)
             + 14'(b_frac[2] * 14'd10) + 14'(b_frac[3]);
    units    = 30'(b_deg * 30'd600000) + 30'(cmin_val * 30'd10000) + 30'(frac_val);
    c_err    = b_err;
    c_seen   = seen_r;
    c_lat    = lat_r;
    c_lon    = lon_r;
    if (is_comma || last) begin
      case (fld_r)
        FLD_HDR: begin
          if (b_pos != HDR_LEN) c_err = 1'b1;
        end
        FLD_TIME: begin
          c_seen = c_seen | SEEN_TIME;
          if (b_pos < TIME_MIN_LEN || b_hour > HOUR_MAX || b_min > MINSEC_MAX
              || b_sec > MINSEC_MAX) c_err = 1'b1;
        end
        FLD_LAT, FLD_LON: begin
          c_seen = c_seen | ((fld_r == FLD_LAT) ? SEEN_LAT : SEEN_LON);
          if (b_pos < COORD_MIN_LEN || !b_dot_seen || !b_dot_ok) begin
            c_err = 1'b1;
          end else if (fld_r == FLD_LAT) begin
            c_lat = units;
          end else begin
            c_lon = units;
          end
        end
        FLD_DATE: begin
          c_seen = c_seen | SEEN_DATE;
          if (b_pos != DATE_LEN || b_day > DAY_MAX || b_mon > MONTH_MAX) c_err = 1'b1;
        end
        default: ;
      endcase
    end

    fld_adv = (fld_r < FLD_MAX) ? fld_r + 4'd1 : fld_r;

    // A comma on the last byte opens an empty field that closes at once
    e_err  = c_err;
    e_seen = c_seen;
    if (is_comma) begin
      case (fld_adv)
        FLD_TIME: begin
          e_seen = e_seen | SEEN_TIME;
          e_err  = 1'b1;
        end
        FLD_LAT: begin
          e_seen = e_seen | SEEN_LAT;
          e_err  = 1'b1;
        end
        FLD_LON: begin
          e_seen = e_seen | SEEN_LON;
          e_err  = 1'b1;
        end
        FLD_DATE: begin
          e_seen = e_seen | SEEN_DATE;
          e_err  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Next state of the parser and the result register
  always_comb begin
    fld_nxt      = fld_r;
    pos_nxt      = pos_r;
    err_nxt      = err_r;
    seen_nxt     = seen_r;
    hour_nxt     = hour_r;
    min_nxt      = min_r;
    sec_nxt      = sec_r;
    day_nxt      = day_r;
    mon_nxt      = mon_r;
    yr_nxt       = yr_r;
    deg_nxt      = deg_r;
    cmt_nxt      = cmt_r;
    cmo_nxt      = cmo_r;
    frac_nxt     = frac_r;
    dot_seen_nxt = dot_seen_r;
    dot_ok_nxt   = dot_ok_r;
    fcnt_nxt     = fcnt_r;
    lat_nxt      = lat_r;
    lon_nxt      = lon_r;
    latl_nxt     = latl_r;
    lonl_nxt     = lonl_r;

    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (accept) begin
      if (last) begin
        // Emit the beat and restart for the next sentence
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        if (!e_err && e_seen == SEEN_ALL) begin
          out_data_nxt.valid_res            = 1'b1;
          out_data_nxt.hour                 = b_hour[4:0];
          out_data_nxt.minute               = b_min[5:0];
          out_data_nxt.second               = b_sec[5:0];
          out_data_nxt.day_of_month         = b_day[4:0];
          out_data_nxt.month_number         = b_mon[3:0];
          out_data_nxt.year_full            = 12'(b_yr) + YEAR_BASE;
          out_data_nxt.latitude_units       = c_lat;
          out_data_nxt.latitude_hemisphere  = b_latl;
          out_data_nxt.longitude_units      = c_lon;
          out_data_nxt.longitude_hemisphere = b_lonl;
        end
        fld_nxt      = FLD_HDR;
        pos_nxt      = '0;
        err_nxt      = 1'b0;
        seen_nxt     = '0;
        hour_nxt     = '0;
        min_nxt      = '0;
        sec_nxt      = '0;
        day_nxt      = '0;
        mon_nxt      = '0;
        yr_nxt       = '0;
        deg_nxt      = '0;
        cmt_nxt      = '0;
        cmo_nxt      = '0;
        frac_nxt     = '{default: '0};
        dot_seen_nxt = 1'b0;
        dot_ok_nxt   = 1'b0;
        fcnt_nxt     = '0;
        lat_nxt      = '0;
        lon_nxt      = '0;
        latl_nxt     = CH_X;
        lonl_nxt     = CH_X;
      end else begin
        err_nxt      = c_err;
        seen_nxt     = c_seen;
        lat_nxt      = c_lat;
        lon_nxt      = c_lon;
        pos_nxt      = b_pos;
        hour_nxt     = b_hour;
        min_nxt      = b_min;
        sec_nxt      = b_sec;
        day_nxt      = b_day;
        mon_nxt      = b_mon;
        yr_nxt       = b_yr;
        deg_nxt      = b_deg;
        cmt_nxt      = b_cmt;
        cmo_nxt      = b_cmo;
        frac_nxt     = b_frac;
        dot_seen_nxt = b_dot_seen;
        dot_ok_nxt   = b_dot_ok;
        fcnt_nxt     = b_fcnt;
        latl_nxt     = b_latl;
        lonl_nxt     = b_lonl;
        if (is_comma) begin
          // Advance to the next field and open it
          fld_nxt = fld_adv;
          pos_nxt = '0;
          if (fld_adv == FLD_LAT || fld_adv == FLD_LON) begin
            deg_nxt      = '0;
            cmt_nxt      = '0;
            cmo_nxt      = '0;
            frac_nxt     = '{default: '0};
            dot_seen_nxt = 1'b0;
            dot_ok_nxt   = 1'b0;
            fcnt_nxt     = '0;
          end
          if (fld_adv == FLD_NS) latl_nxt = '0;
          if (fld_adv == FLD_EW) lonl_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fld_r       <= FLD_HDR;
      pos_r       <= '0;
      err_r       <= 1'b0;
      seen_r      <= '0;
      hour_r      <= '0;
      min_r       <= '0;
      sec_r       <= '0;
      day_r       <= '0;
      mon_r       <= '0;
      yr_r        <= '0;
      deg_r       <= '0;
      cmt_r       <= '0;
      cmo_r       <= '0;
      frac_r      <= '{default: '0};
      dot_seen_r  <= 1'b0;
      dot_ok_r    <= 1'b0;
      fcnt_r      <= '0;
      lat_r       <= '0;
      lon_r       <= '0;
      latl_r      <= CH_X;
      lonl_r      <= CH_X;
      out_valid_r <= 1'b0;
    end else begin
      fld_r       <= fld_nxt;
      pos_r       <= pos_nxt;
      err_r       <= err_nxt;
      seen_r      <= seen_nxt;
      hour_r      <= hour_nxt;
      min_r       <= min_nxt;
      sec_r       <= sec_nxt;
      day_r       <= day_nxt;
      mon_r       <= mon_nxt;
      yr_r        <= yr_nxt;
      deg_r       <= deg_nxt;
      cmt_r       <= cmt_nxt;
      cmo_r       <= cmo_nxt;
      frac_r      <= frac_nxt;
      dot_seen_r  <= dot_seen_nxt;
      dot_ok_r    <= dot_ok_nxt;
      fcnt_r      <= fcnt_nxt;
      lat_r       <= lat_nxt;
      lon_r       <= lon_nxt;
      latl_r      <= latl_nxt;
      lonl_r      <= lonl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload needs no reset; hold it while the beat is stalled
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the RMC sentence parser: directed sentences, then random traffic.
module tb;
  import nrmc_pkg::*;

  // Keep the same number of fraction digits as the block's default.
  localparam int KEEP_FRAC = (FRAC_DIGITS_DEF < 4) ? FRAC_DIGITS_DEF : 4;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES = 80;
  localparam logic [47:0] HEADER_TEXT = "$GPRMC";

  // Known-good sample sentence, decoded by hand.
  localparam out_t SAMPLE_FIX = '{valid_res: 1'b1, hour: 5'd12, minute: 6'd35, second: 6'd19,
                                  day_of_month: 5'd23, month_number: 4'd3, year_full: 12'd2094,
                                  latitude_units: 30'd28870380, latitude_hemisphere: 8'h4E,
                                  longitude_units: 30'd6910000, longitude_hemisphere: 8'h45};

  // How a directed row gets its expected result.
  typedef enum logic [1:0] {ROW_PREDICT, ROW_REJECT, ROW_SAMPLE} row_kind_t;

  localparam int N_ROWS = 22;

  string dir_text [N_ROWS] = '{
    "$GPRMC,123519.00,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W",
    "$GPGGA,123519.00,A,4807.038,N,01131.000,E,,,230394",
    "$GPRMC,240000.,A,4807.038,N,01131.000,E,,,230394",
    "$GPRMC,126000.,A,4807.038,N,01131.000,E,,,230394",
    "$GPRMC,120060.,A,4807.038,N,01131.000,E,,,230394",
    "$GPRMC,123519.,A,4807.038,N,01131.000,E,,,320194",
    "$GPRMC,123519.,A,4807.038,N,01131.000,E,,,011394",
    "$GPRMC,235959.,A,8959.9999,S,17959.9999,W",
    "$GPRMC,235959.999,A,8959.99999999,S,99999.9999,W,,,311299,,,A",
    "$GPRMC,123519.,A,12345.678,N,01131.000,E,,,230394",
    "$GPRMC,123519.,A,4807.03.8,N,01131.000,E,,,230394",
    "$GPRMC,000000.x/Z,V,123.4567,,000.000,,,,010100",
    "$GPRMC,010203.,,0000.0000,N,00000.0000,E,AAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAA,,000000,,,,,,,,",
    "$GPRMC,12a519.,A,4807.038,N,01131.000,E,,,230394",
    "$GPRMC,123519.,A,0000.0,N,01131.000,E,,,230394",
    "$GPRMC,123519.,A,12.34567,N,01131.000,E,,,230394",
    "$GPRMCX,123519.,A,4807.038,N,01131.000,E,,,230394",
    "$GPRMC,123519.,A,4807.038,N,01131.000,E,,,2303944",
    ",",
    "$GPRMC,123519.,A,4807.038,N,01131.000,E,,,23o394",
    "$GPRMC",
    "$GPRMC,123519.,A,4807.038,N,01131.000,E,,,230394,"
  };

  row_kind_t dir_kind [N_ROWS] = '{
    ROW_SAMPLE,  ROW_REJECT, ROW_REJECT, ROW_REJECT, ROW_REJECT, ROW_REJECT,
    ROW_REJECT,  ROW_REJECT, ROW_PREDICT, ROW_PREDICT, ROW_REJECT, ROW_PREDICT,
    ROW_PREDICT, ROW_REJECT, ROW_REJECT, ROW_REJECT, ROW_REJECT, ROW_REJECT,
    ROW_REJECT,  ROW_REJECT, ROW_REJECT, ROW_PREDICT
  };

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  nmea_rmc_sentence_parser_top #(.FRAC_DIGITS(FRAC_DIGITS_DEF)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Parser state as tracked by the testbench.
  logic [3:0]  fld;
  logic [4:0]  pos;
  logic        err;
  logic [3:0]  seen;
  logic [6:0]  hh, mm, ss;
  logic [20:0] date_acc;
  logic [9:0]  deg;
  logic [6:0]  mins;
  logic [13:0] frac;
  logic [5:0]  dot_at;       // dot index + 1, zero while no dot seen
  logic [2:0]  nfrac;
  logic [29:0] lat_u, lon_u;
  logic [7:0]  lat_h, lon_h;

  out_t        expected_fixes[$];
  logic [7:0]  sentence_bytes[$];
  row_kind_t   cur_kind = ROW_PREDICT;

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int bytes_sent = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up if the run stalls.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic clear_rmc_state();
    fld = '0; pos = '0; err = 1'b0; seen = '0;
    hh = '0; mm = '0; ss = '0; date_acc = '0;
    deg = '0; mins = '0; frac = '0; dot_at = '0; nfrac = '0;
    lat_u = '0; lon_u = '0; lat_h = CH_X; lon_h = CH_X;
  endtask

  // Close the current field: mark it seen, run its length and range checks and store a coordinate.
  task automatic close_rmc_field();
    int unsigned units, f4;
    case (fld)
      FLD_HDR: if (pos != HDR_LEN) err = 1'b1;
      FLD_TIME: begin
        seen |= SEEN_TIME;
        if (pos < TIME_MIN_LEN || hh > HOUR_MAX || mm > MINSEC_MAX || ss > MINSEC_MAX)
          err = 1'b1;
      end
      FLD_LAT, FLD_LON: begin
        seen |= (fld == FLD_LAT) ? SEEN_LAT : SEEN_LON;
        if (pos < COORD_MIN_LEN || dot_at < DOT_POS_MIN + 1 || dot_at > DOT_POS_MAX + 1) begin
          err = 1'b1;
        end else begin
          // Pad the kept fraction digits out to four.
          f4 = frac;
          for (int n = nfrac; n < 4; n++) f4 = f4 * 10;
          units = deg * 600000 + mins * 10000 + f4;
          if (fld == FLD_LAT) lat_u = 30'(units);
          else lon_u = 30'(units);
        end
      end
      FLD_DATE: begin
        seen |= SEEN_DATE;
        if (pos != DATE_LEN || date_acc / 10000 > DAY_MAX || (date_acc / 100) % 100 > MONTH_MAX)
          err = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Advance the tracked parser by one beat; return the fix when the sentence ends.
  task automatic track_rmc_byte(input logic [7:0] ch, input logic is_last,
                                output logic got_fix, output out_t fix);
    logic [7:0] d;
    logic digit;
    d = ch - CH_0;
    digit = (ch >= CH_0) && (ch <= CH_9);
    got_fix = 1'b0;
    fix = '0;
    if (ch == CH_COMMA) begin
      close_rmc_field();
      if (fld < FLD_MAX) fld++;
      pos = '0;
      if (fld == FLD_LAT || fld == FLD_LON) begin
        deg = '0; mins = '0; frac = '0; dot_at = '0; nfrac = '0;
      end
      if (fld == FLD_NS) lat_h = '0;
      if (fld == FLD_EW) lon_h = '0;
    end else begin
      case (fld)
        FLD_HDR: if (pos < HDR_LEN && ch != HEADER_TEXT[47 - 8 * pos -: 8]) err = 1'b1;
        FLD_TIME: begin
          if (pos < TIME_DIGITS) begin
            if (!digit) err = 1'b1;
            else if (pos < 2) hh = hh * 10 + d;
            else if (pos < 4) mm = mm * 10 + d;
            else ss = ss * 10 + d;
          end else if (pos == TIME_DIGITS && ch != CH_DOT) begin
            err = 1'b1;
          end
        end
        FLD_LAT, FLD_LON: begin
          if (dot_at == 0) begin
            if (ch == CH_DOT) dot_at = pos + 6'd1;
            else if (!digit) err = 1'b1;
            else if (pos < COORD_DIGITS) begin
              // Shift the digit window: the last two digits are minutes.
              deg = deg * 10 + mins / 10;
              mins = (mins % 10) * 10 + d;
            end
          end else if (!digit) begin
            err = 1'b1;
          end else if (nfrac < KEEP_FRAC) begin
            frac = frac * 10 + d;
            nfrac++;
          end
        end
        FLD_NS: if (pos == 0) lat_h = ch;
        FLD_EW: if (pos == 0) lon_h = ch;
        FLD_DATE: begin
          if (pos < DATE_LEN) begin
            if (!digit) err = 1'b1;
            else date_acc = date_acc * 10 + d;
          end
        end
        default: ;
      endcase
      if (pos < POS_MAX) pos++;
    end
    if (is_last) begin
      close_rmc_field();
      got_fix = 1'b1;
      if (!err && seen == SEEN_ALL) begin
        fix.valid_res = 1'b1;
        fix.hour = 5'(hh);
        fix.minute = 6'(mm);
        fix.second = 6'(ss);
        fix.day_of_month = 5'(date_acc / 10000);
        fix.month_number = 4'((date_acc / 100) % 100);
        fix.year_full = 12'(date_acc % 100 + YEAR_BASE);
        fix.latitude_units = lat_u;
        fix.latitude_hemisphere = lat_h;
        fix.longitude_units = lon_u;
        fix.longitude_hemisphere = lon_h;
      end
      clear_rmc_state();
    end
  endtask

  // Offer one beat, idling first at random, and hold it until taken.
  task automatic send_byte(input logic [7:0] ch, input logic is_last);
    logic got_fix;
    out_t fix;
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{char_in: ch, end_of_sentence: is_last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    track_rmc_byte(ch, is_last, got_fix, fix);
    if (got_fix) begin
      case (cur_kind)
        ROW_REJECT: expected_fixes.push_back('0);
        ROW_SAMPLE: expected_fixes.push_back(SAMPLE_FIX);
        default:    expected_fixes.push_back(fix);
      endcase
    end
  endtask

  task automatic send_sentence();
    for (int i = 0; i < sentence_bytes.size(); i++)
      send_byte(sentence_bytes[i], i == sentence_bytes.size() - 1);
  endtask

  // Drop valid and wait until every expected fix has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_fixes.size() != 0) @(posedge clk);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) sentence_bytes.push_back(s[i]);
  endtask

  task automatic add_digits(input int n);
    repeat (n) sentence_bytes.push_back(8'($urandom_range(CH_0, CH_9)));
  endtask

  // Coordinate ddmm.f with mostly the usual degree width and a legal length.
  task automatic add_coord(input int usual_deg);
    int n, f;
    n = ($urandom_range(7) == 0) ? $urandom_range(0, 4) : usual_deg;
    add_digits(n);
    add_digits(2);
    add_text(".");
    f = ($urandom_range(9) == 0) ? $urandom_range(0, 8)
                                 : $urandom_range((4 - n > 1) ? 4 - n : 1, 7);
    add_digits(f);
  endtask

  task automatic add_hemisphere(input string a, input string b);
    int r;
    r = $urandom_range(99);
    if (r < 45) add_text(a);
    else if (r < 90) add_text(b);
    else if (r < 95) add_text("");
    else add_text($sformatf("%c", $urandom_range(33, 126)));
  endtask

  // RMC sentences with random content, some out of range or damaged; noise_pct percent are noise.
  task automatic build_random_sentence(input int noise_pct);
    int r, idx, hr, mn, sc, dy, mo;
    sentence_bytes.delete();
    if ($urandom_range(99) < noise_pct) begin
      repeat ($urandom_range(1, 6)) sentence_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    r = $urandom_range(99);
    add_text(r < 92 ? "$GPRMC" : (r < 96 ? "$GPRMA" : "$GPRM"));
    hr = ($urandom_range(9) == 0) ? $urandom_range(20, 29) : $urandom_range(0, 23);
    mn = ($urandom_range(9) == 0) ? $urandom_range(50, 69) : $urandom_range(0, 59);
    sc = ($urandom_range(9) == 0) ? $urandom_range(50, 69) : $urandom_range(0, 59);
    add_text($sformatf(",%02d%02d%02d.", hr, mn, sc));
    add_digits($urandom_range(0, 3));
    add_text($urandom_range(1) ? ",A," : ",V,");
    add_coord(2);
    add_text(",");
    add_hemisphere("N", "S");
    add_text(",");
    add_coord(3);
    add_text(",");
    add_hemisphere("E", "W");
    if ($urandom_range(1))
      add_text($sformatf(",%0d.%0d,%0d.%0d,", $urandom_range(999), $urandom_range(9),
                         $urandom_range(359), $urandom_range(9)));
    else
      add_text(",,,");
    dy = ($urandom_range(9) == 0) ? $urandom_range(28, 39) : $urandom_range(0, 31);
    mo = ($urandom_range(9) == 0) ? $urandom_range(10, 19) : $urandom_range(0, 12);
    add_text($sformatf("%02d%02d%02d", dy, mo, $urandom_range(99)));
    r = $urandom_range(3);
    if (r == 1) add_text(",,A");
    else if (r == 2) add_text(",003.1,W,A*6A");
    // Damage a few: overwrite, drop, cut short or insert a byte.
    if ($urandom_range(99) < 15) begin
      idx = $urandom_range(sentence_bytes.size() - 1);
      case ($urandom_range(3))
        0: sentence_bytes[idx] = 8'($urandom_range(255));
        1: sentence_bytes.delete(idx);
        2: while (sentence_bytes.size() > idx + 1) void'(sentence_bytes.pop_back());
        default: sentence_bytes.insert(idx, $urandom_range(1) ? CH_COMMA
                                                 : 8'($urandom_range(CH_0, CH_9)));
      endcase
    end
  endtask

  // Random traffic under one idling setting; pause at the end until drained.
  task automatic run_phase(input int snd_pct, input int rcv_pct);
    int sentences, start_bytes;
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    sentences = 0;
    start_bytes = bytes_sent;
    while (sentences < 1 || bytes_sent - start_bytes < 40) begin
      build_random_sentence(30);
      send_sentence();
      sentences++;
    end
    wait_drained();
  endtask

  // Receiver: random stalls, plus a long hold-off when the sender asks for one.
  always @(posedge clk) begin
    if (holds_asked != holds_done) begin
      holds_done = holds_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (rcv_stall_pct != 0) && ($urandom_range(99) < rcv_stall_pct);
    end
  end

  function automatic string fix_text(input out_t f);
    return $sformatf("v=%0d %0d:%0d:%0d %0d/%0d/%0d lat=%0d/%02h lon=%0d/%02h",
                     f.valid_res, f.hour, f.minute, f.second, f.day_of_month,
                     f.month_number, f.year_full, f.latitude_units, f.latitude_hemisphere,
                     f.longitude_units, f.longitude_hemisphere);
  endfunction

  task automatic report_mismatch(input string what, input out_t want, input out_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch (%s): expected %s | got %s", what, fix_text(want), fix_text(got));
  endtask

  // Check each fix taken from the block against the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_fixes.size() == 0) begin
        report_mismatch("nothing expected", '0, out_data);
      end else begin
        if (out_data !== expected_fixes[0])
          report_mismatch("field", expected_fixes[0], out_data);
        void'(expected_fixes.pop_front());
      end
    end
  end

  initial begin
    clear_rmc_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sentences, back to back.
    for (int r = 0; r < N_ROWS; r++) begin
      sentence_bytes.delete();
      add_text(dir_text[r]);
      cur_kind = dir_kind[r];
      send_sentence();
    end
    cur_kind = ROW_PREDICT;
    wait_drained();

    run_phase(0, 0);

    // Hold the receiver off while short sentences keep coming, so the input backs up.
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    holds_asked++;
    repeat (12) begin
      build_random_sentence(100);
      send_sentence();
    end
    wait_drained();

    run_phase(61, 0);
    run_phase(0, 61);
    run_phase(15, 15);

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
